// ----- rtl/assert_macros.svh -----
// Assertion macros used by the datapath RTL file of the path sweeper
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/cmrps_pkg.sv -----
// Types and constants of the Catmull-Rom path sweeper
package cmrps_pkg;

    localparam int NUM_WAYS = 5;
    localparam int WAY_AW   = 3;
    localparam int CRD_W    = 32;
    localparam int WORD_W   = 3 * CRD_W;
    localparam int TICK_W   = 16;
    localparam int CNT_W    = 18;
    localparam int T_W      = 17;
    localparam int ACC_W    = 40;
    localparam int PROD_W   = ACC_W + T_W + 1;
    localparam int STEP_W   = 4;
    localparam int FRAC_SH  = 16;

    localparam logic [2:0]        LAST_SEG  = 3'd4;
    localparam logic [2:0]        FIRST_SEG = 3'd1;
    localparam logic [T_W-1:0]    T_ONE     = 17'h10000;
    localparam logic [STEP_W-1:0] DIV_LAST  = 4'd15;
    localparam logic [TICK_W-1:0] TICKS_RST = 16'd16;

    localparam logic signed [ACC_W-1:0] SAT_MAX = 40'sh00_7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] SAT_MIN = -40'sh00_8000_0000;

    // input item kinds
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CNT,
        S_SEG,
        S_FRAC,
        S_DIVI,
        S_DIV,
        S_COEF,
        S_MUL,
        S_ADD,
        S_FIN
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load_way;
        logic tick_start;
        logic count;
        logic seg;
        logic frac;
        logic div_init;
        logic div_step;
        logic coef;
        logic mul;
        logic add;
        logic fin;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic active;
        logic div_done;
        logic h_last;
        logic can_load;
    } t_stat;

endpackage

// ----- rtl/cmrps_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module cmrps_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 5,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/cmrps_ctrl.sv -----
// Sequencing state machine of the path sweeper
module cmrps_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_func,
    input  cmrps_pkg::t_stat i_stat,
    output cmrps_pkg::t_cmd  o_cmd,
    output logic             o_in_stall
);

    cmrps_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cmrps_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            cmrps_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_func == cmrps_pkg::FUNC_TICK) begin
                        o_cmd.tick_start = 1'b1;
                        n_state          = cmrps_pkg::S_CNT;
                    end else begin
                        o_cmd.load_way = 1'b1;
                    end
                end
            end
            cmrps_pkg::S_CNT: begin
                if (i_stat.active) begin
                    o_cmd.count = 1'b1;
                    n_state     = cmrps_pkg::S_SEG;
                end else begin
                    n_state = cmrps_pkg::S_IDLE;
                end
            end
            cmrps_pkg::S_SEG: begin
                o_cmd.seg = 1'b1;
                n_state   = cmrps_pkg::S_FRAC;
            end
            cmrps_pkg::S_FRAC: begin
                o_cmd.frac = 1'b1;
                n_state    = cmrps_pkg::S_DIVI;
            end
            cmrps_pkg::S_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_state        = cmrps_pkg::S_DIV;
            end
            cmrps_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = cmrps_pkg::S_COEF;
                end
            end
            cmrps_pkg::S_COEF: begin
                o_cmd.coef = 1'b1;
                n_state    = cmrps_pkg::S_MUL;
            end
            cmrps_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = cmrps_pkg::S_ADD;
            end
            cmrps_pkg::S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = i_stat.h_last ? cmrps_pkg::S_FIN : cmrps_pkg::S_MUL;
            end
            cmrps_pkg::S_FIN: begin
                o_cmd.fin = 1'b1;
                if (i_stat.can_load) begin
                    n_state = cmrps_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cmrps_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/cmrps_dp.sv -----
// Datapath: waypoint store, sweep counters, fraction divider, Horner evaluator
`include "assert_macros.svh"

module cmrps_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  cmrps_pkg::t_cmd                      i_cmd,
    output cmrps_pkg::t_stat                     o_stat,
    input  logic                                 i_cfg_we,
    input  logic [cmrps_pkg::TICK_W-1:0]         i_cfg_data,
    input  logic [2:0]                           i_slot,
    input  logic signed [cmrps_pkg::CRD_W-1:0]   i_px,
    input  logic signed [cmrps_pkg::CRD_W-1:0]   i_py,
    input  logic signed [cmrps_pkg::CRD_W-1:0]   i_pz,
    input  logic                                 i_trigger,
    input  logic                                 i_out_stall,
    output logic                                 o_out_valid,
    output logic                                 o_still_active,
    output logic signed [cmrps_pkg::CRD_W-1:0]   o_pos_x,
    output logic signed [cmrps_pkg::CRD_W-1:0]   o_pos_y,
    output logic signed [cmrps_pkg::CRD_W-1:0]   o_pos_z,
    output logic [2:0]                           o_segment
);

    localparam int CW = cmrps_pkg::CRD_W;
    localparam int AW = cmrps_pkg::ACC_W;

    // config and sweep state
    logic [cmrps_pkg::TICK_W-1:0]  r_seg_ticks;
    logic                          r_active;
    logic [cmrps_pkg::CNT_W-1:0]   r_tc;
    logic [cmrps_pkg::CNT_W-1:0]   r_ss;
    logic [2:0]                    r_si;
    logic [cmrps_pkg::CNT_W-1:0]   r_e;
    logic                          r_full;

    // divider
    logic [cmrps_pkg::TICK_W-1:0]  r_rem;
    logic [cmrps_pkg::TICK_W-1:0]  r_quo;
    logic [cmrps_pkg::STEP_W-1:0]  r_step;
    logic [cmrps_pkg::T_W-1:0]     r_t;

    // evaluator
    logic signed [CW-1:0]                     r_q    [3][4];
    logic signed [AW-1:0]                     r_c    [3][4];
    logic signed [AW-1:0]                     r_acc  [3];
    logic signed [cmrps_pkg::PROD_W-1:0]      r_prod [3];
    logic [1:0]                               r_hk;

    // output register
    logic                  r_out_valid;
    logic                  r_out_act;
    logic signed [CW-1:0]  r_pos [3];
    logic [2:0]            r_out_seg;

    logic [cmrps_pkg::TICK_W-1:0]  w_ticks;
    logic [cmrps_pkg::CNT_W-1:0]   w_ticks_x;
    logic [cmrps_pkg::WORD_W-1:0]  w_rdata;
    logic [cmrps_pkg::WAY_AW-1:0]  w_raddr;
    logic [2:0]                    w_ci;
    logic [cmrps_pkg::TICK_W:0]    w_r2;
    logic                          w_qbit;
    logic [cmrps_pkg::STEP_W-1:0]  w_cap;
    logic                          w_can_load;
    logic signed [AW-1:0]          w_c    [3][4];
    logic signed [AW-1:0]          w_half [3];
    logic signed [CW-1:0]          w_sat  [3];

    assign w_ticks   = (r_seg_ticks == '0) ? {{(cmrps_pkg::TICK_W-1){1'b0}}, 1'b1}
                                           : r_seg_ticks;
    assign w_ticks_x = {2'b00, w_ticks};

    // waypoint store, {z, y, x} per entry
    cmrps_ram #(
        .WIDTH (cmrps_pkg::WORD_W),
        .DEPTH (cmrps_pkg::NUM_WAYS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_way && (i_slot < 3'(cmrps_pkg::NUM_WAYS))),
        .i_waddr (i_slot),
        .i_wdata ({i_pz, i_py, i_px}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // control list index -> waypoint: first and last points repeat
    always_comb begin
        w_ci = r_si - 3'd1 + {1'b0, r_step[1:0]};
        if (w_ci == 3'd0) begin
            w_raddr = 3'd0;
        end else if (w_ci >= 3'd6) begin
            w_raddr = 3'd4;
        end else begin
            w_raddr = w_ci - 3'd1;
        end
    end

    // one quotient bit per step
    assign w_r2   = {r_rem, 1'b0};
    assign w_qbit = (w_r2 >= {1'b0, w_ticks});
    assign w_cap  = r_step - 4'd1;

    // spline coefficients per axis
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            logic signed [AW-1:0] q0, q1, q2, q3;
            q0 = {{(AW-CW){r_q[a][0][CW-1]}}, r_q[a][0]};
            q1 = {{(AW-CW){r_q[a][1][CW-1]}}, r_q[a][1]};
            q2 = {{(AW-CW){r_q[a][2][CW-1]}}, r_q[a][2]};
            q3 = {{(AW-CW){r_q[a][3][CW-1]}}, r_q[a][3]};
            w_c[a][0] = q1 <<< 1;
            w_c[a][1] = q2 - q0;
            w_c[a][2] = (q0 <<< 1) - (q1 <<< 2) - q1 + (q2 <<< 2) - q3;
            w_c[a][3] = q1 + (q1 <<< 1) - q2 - (q2 <<< 1) + q3 - q0;
        end
    end

    // halve and saturate
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_half[a] = r_acc[a] >>> 1;
            if (w_half[a] > cmrps_pkg::SAT_MAX) begin
                w_sat[a] = cmrps_pkg::SAT_MAX[CW-1:0];
            end else if (w_half[a] < cmrps_pkg::SAT_MIN) begin
                w_sat[a] = cmrps_pkg::SAT_MIN[CW-1:0];
            end else begin
                w_sat[a] = w_half[a][CW-1:0];
            end
        end
    end

    assign w_can_load = !r_out_valid || !i_out_stall;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_ticks <= cmrps_pkg::TICKS_RST;
            r_active    <= 1'b0;
            r_tc        <= '0;
            r_ss        <= '0;
            r_si        <= cmrps_pkg::FIRST_SEG;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_seg_ticks <= i_cfg_data;
            end
            if (i_cmd.tick_start && i_trigger) begin
                r_active <= 1'b1;
                r_tc     <= '0;
                r_ss     <= '0;
                r_si     <= cmrps_pkg::FIRST_SEG;
            end
            if (i_cmd.count) begin
                if (r_tc < {w_ticks, 2'b00}) begin
                    r_tc <= r_tc + 18'd1;
                end else begin
                    r_active <= 1'b0;
                end
            end
            if (i_cmd.frac && (r_e >= w_ticks_x) && (r_si < cmrps_pkg::LAST_SEG)) begin
                r_si <= r_si + 3'd1;
                r_ss <= r_tc;
            end
            if (i_cmd.fin && w_can_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.seg) begin
            r_e <= r_tc - r_ss;
        end
        if (i_cmd.frac) begin
            r_full <= 1'b0;
            if (r_e >= w_ticks_x) begin
                if (r_si < cmrps_pkg::LAST_SEG) begin
                    r_e <= r_e - w_ticks_x;
                end else begin
                    r_full <= 1'b1;
                end
            end
        end
        if (i_cmd.div_init) begin
            r_full <= r_full || (r_e >= w_ticks_x);
            r_rem  <= r_e[cmrps_pkg::TICK_W-1:0];
            r_quo  <= '0;
            r_step <= '0;
        end
        if (i_cmd.div_step) begin
            r_step <= r_step + 4'd1;
            r_quo  <= {r_quo[cmrps_pkg::TICK_W-2:0], w_qbit};
            r_rem  <= w_qbit ? 16'(w_r2 - {1'b0, w_ticks}) : w_r2[cmrps_pkg::TICK_W-1:0];
            if ((r_step != '0) && (r_step <= 4'd4)) begin
                for (int a = 0; a < 3; a++) begin
                    r_q[a][w_cap[1:0]] <= w_rdata[a*CW +: CW];
                end
            end
        end
        if (i_cmd.coef) begin
            r_t  <= r_full ? cmrps_pkg::T_ONE : {1'b0, r_quo};
            r_hk <= 2'd2;
            for (int a = 0; a < 3; a++) begin
                for (int k = 0; k < 4; k++) begin
                    r_c[a][k] <= w_c[a][k];
                end
                r_acc[a] <= w_c[a][3];
            end
        end
        if (i_cmd.mul) begin
            for (int a = 0; a < 3; a++) begin
                r_prod[a] <= r_acc[a] * $signed({1'b0, r_t});
            end
        end
        if (i_cmd.add) begin
            r_hk <= r_hk - 2'd1;
            for (int a = 0; a < 3; a++) begin
                r_acc[a] <= AW'(r_prod[a] >>> cmrps_pkg::FRAC_SH) + r_c[a][r_hk];
            end
        end
        if (i_cmd.fin && w_can_load) begin
            r_out_act <= r_active;
            r_out_seg <= r_si;
            for (int a = 0; a < 3; a++) begin
                r_pos[a] <= w_sat[a];
            end
        end
    end

    assign o_stat.active   = r_active;
    assign o_stat.div_done = (r_step == cmrps_pkg::DIV_LAST);
    assign o_stat.h_last   = (r_hk == 2'd0);
    assign o_stat.can_load = w_can_load;

    assign o_out_valid    = r_out_valid;
    assign o_still_active = r_out_act;
    assign o_pos_x        = r_pos[0];
    assign o_pos_y        = r_pos[1];
    assign o_pos_z        = r_pos[2];
    assign o_segment      = r_out_seg;

    // checks
    `ASSERT_NEVER(a_seg_range, (r_si < cmrps_pkg::FIRST_SEG) || (r_si > cmrps_pkg::LAST_SEG),
        "segment index out of range")
    `ASSERT_CLK(a_rem_bound, (i_cmd.div_step && !r_full) |-> ({1'b0, r_rem} < {1'b0, w_ticks}),
        "divider remainder not below divisor")
    `ASSERT_CLK(a_fin_loads, (i_cmd.fin && w_can_load) |=> r_out_valid,
        "finished result not presented")

endmodule

// ----- rtl/catmull_rom_path_sweeper.sv -----
// Top level of the Catmull-Rom path sweeper
//
// A load beat (func 0) writes one of five waypoints. A tick
// beat (func 1) that finds the sweep active, or restarts it by trigger, gives
// one interpolated position after counter and segment update, a bit-serial
// divider that forms the Q0.16 fraction (the four control points are read
// from the waypoint RAM during it), then three multiply/add passes of the
// Horner evaluator and a saturation stage. One tick is worked at a
// time; the next beat is taken while a finished result waits in the output
// register. seg_ticks may be written only while the block is idle.
module catmull_rom_path_sweeper (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cmrps_pkg::TICK_W-1:0]        i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_func,
    input  logic [2:0]                          i_slot,
    input  logic signed [cmrps_pkg::CRD_W-1:0]  i_px,
    input  logic signed [cmrps_pkg::CRD_W-1:0]  i_py,
    input  logic signed [cmrps_pkg::CRD_W-1:0]  i_pz,
    input  logic                                i_trigger,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_still_active,
    output logic signed [cmrps_pkg::CRD_W-1:0]  o_pos_x,
    output logic signed [cmrps_pkg::CRD_W-1:0]  o_pos_y,
    output logic signed [cmrps_pkg::CRD_W-1:0]  o_pos_z,
    output logic [2:0]                          o_segment
);

    cmrps_pkg::t_cmd  w_cmd;
    cmrps_pkg::t_stat w_stat;

    cmrps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    cmrps_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_slot         (i_slot),
        .i_px           (i_px),
        .i_py           (i_py),
        .i_pz           (i_pz),
        .i_trigger      (i_trigger),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_still_active (o_still_active),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_pos_z        (o_pos_z),
        .o_segment      (o_segment)
    );

endmodule
